FILE: hw/rtl/oeit_pkg.sv
// Shared types and codes for the order event to ITCH translator.
package oeit_pkg;

    typedef enum logic [1:0] {
        REQ_RESEED = 2'd0,
        REQ_ACCEPT = 2'd1,
        REQ_CANCEL = 2'd2,
        REQ_TRADE  = 2'd3
    } req_kind_t;

    localparam logic [1:0] RSN_WITHDRAW = 2'd0;
    localparam logic [1:0] RSN_REPLACE  = 2'd1;
    localparam logic [1:0] RSN_IOC      = 2'd2;
    localparam logic [1:0] RSN_FOK      = 2'd3;

    localparam logic [2:0] MSG_ADD      = 3'd0;
    localparam logic [2:0] MSG_CANCEL   = 3'd1;
    localparam logic [2:0] MSG_REPLACE  = 3'd2;
    localparam logic [2:0] MSG_EXECUTED = 3'd3;
    localparam logic [2:0] MSG_DELETE   = 3'd4;

    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 296;

    typedef struct packed {
        req_kind_t   kind;
        logic [63:0] event_time;
        logic [31:0] order_id;
        logic        side;
        logic [31:0] quantity;
        logic [18:0] price_tick;
        logic [1:0]  cancel_reason;
        logic [31:0] maker_left;
    } item_t;

endpackage

FILE: hw/rtl/order_event_to_itch_translator_core.sv
// Top level of the order event to ITCH order message translator.
// Events enter a front register that unpacks them and drops IOC/FOK cancels,
// pass through a two-entry queue, and are executed by a back sequencer that
// owns the live and pending order tables. An accept, cancel or trade passes
// through the back sequencer's steps in order (take from the queue, id search,
// slot choice and table read, execute), and the next event is taken only after
// the execute step; the execute cycle also waits while the output register
// still holds a result that has not been taken. A reseed with live entries
// reads and checks every slot in turn (with waits on the output register) and
// emits one Delete per live entry in slot order; a reseed with an empty table
// emits nothing. Result transactions sit in an output register, so the next
// event is taken while a result waits.
module order_event_to_itch_translator_core #(
    parameter int ORDER_SLOTS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: event_time[63:0], order_id[95:64], side[96], quantity[128:97],
    //        price_tick[147:129], cancel_reason[149:148],
    //        maker_left[181:150], zero pad
    input  logic [oeit_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: msg_time[63:0], order_ref[119:64], old_ref[175:120],
    //        msg_side[176], msg_qty[208:177], msg_tick[227:209],
    //        match_number[291:228], zero pad
    output logic [oeit_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: msg_type[2:0], overflow[3]
    output logic [3:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);
    import oeit_pkg::*;

    logic  f_valid;
    logic  f_ready;
    item_t f_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    oeit_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .dn_valid      (f_valid),
        .dn_ready      (f_ready),
        .dn_item       (f_item)
    );

    oeit_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    oeit_back #(
        .ORDER_SLOTS (ORDER_SLOTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (q_valid),
        .up_ready      (q_ready),
        .up_item       (q_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // old reference only on replace
    a_oref_replace: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2:0] != MSG_REPLACE) |-> (m_axis_tdata[175:120] == '0))
        else $error("old_ref set on a non-replace message");

    // overflow only on add or replace
    a_ovf_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[3]) |->
        (m_axis_tuser[2:0] == MSG_ADD || m_axis_tuser[2:0] == MSG_REPLACE))
        else $error("overflow on a message that does not add an order");

    // match number only on executed
    a_match_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2:0] != MSG_EXECUTED) |->
        (m_axis_tdata[291:228] == '0))
        else $error("match number on a non-executed message");

    // dropped front items never reach the queue as IOC or FOK cancels
    a_front_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (f_valid && f_item.kind == REQ_CANCEL) |->
        (f_item.cancel_reason != RSN_IOC && f_item.cancel_reason != RSN_FOK))
        else $error("IOC or FOK cancel passed the front stage");

endmodule

FILE: hw/rtl/oeit_front.sv
// Front stage: accepts event transactions, unpacks and classifies them.
module oeit_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: event_time, order_id, side, quantity, price_tick, cancel_reason,
    //        maker_left, zero pad
    input  logic [oeit_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: req_type
    input  logic [1:0]                     s_axis_tuser,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output oeit_pkg::item_t                dn_item
);
    import oeit_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t in_item;
    logic  in_drop;

    // unpack fields
    always_comb
    begin
        in_item.kind            = req_kind_t'(s_axis_tuser);
        in_item.event_time      = s_axis_tdata[63:0];
        in_item.order_id        = s_axis_tdata[95:64];
        in_item.side            = s_axis_tdata[96];
        in_item.quantity        = s_axis_tdata[128:97];
        in_item.price_tick      = s_axis_tdata[147:129];
        in_item.cancel_reason   = s_axis_tdata[149:148];
        in_item.maker_left      = s_axis_tdata[181:150];
    end

    // IOC and FOK cancels have no effect at all; drop them here
    assign in_drop = (in_item.kind == REQ_CANCEL) &&
                     ((in_item.cancel_reason == RSN_IOC) ||
                      (in_item.cancel_reason == RSN_FOK));

    assign s_axis_tready = !valid_reg || dn_ready;
    assign dn_valid      = valid_reg;
    assign dn_item       = item_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid && !in_drop;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

FILE: hw/rtl/oeit_queue.sv
// Two-entry queue between the front and back stages.
module oeit_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  oeit_pkg::item_t wr_item,
    output logic            rd_valid,
    input  logic            rd_ready,
    output oeit_pkg::item_t rd_item
);
    import oeit_pkg::*;

    item_t      slots_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = slots_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wptr_reg] <= wr_item;
        end
    end

endmodule

FILE: hw/rtl/oeit_back.sv
// Back stage: order tables, message generation and the output register.
module oeit_back #(
    parameter int ORDER_SLOTS = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  oeit_pkg::item_t up_item,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // tdata: msg_time, order_ref, old_ref, msg_side, msg_qty, msg_tick,
    //        match_number, zero pad
    output logic [oeit_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: msg_type, overflow
    output logic [3:0]      m_axis_tuser,
    output logic            m_axis_tlast
);
    import oeit_pkg::*;

    localparam int IDX_W = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ORDER_SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_EXEC,
        ST_FL_RD,
        ST_FL_EMIT
    } state_t;

    // lowest set bit
    function automatic logic [IDX_W-1:0] lowest(input logic [ORDER_SLOTS-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int k = ORDER_SLOTS - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                r = IDX_W'(k);
            end
        end
        return r;
    endfunction

    state_t                 state_reg;
    item_t                  item_reg;
    logic [ORDER_SLOTS-1:0] live_valid_reg;
    logic [ORDER_SLOTS-1:0] pend_valid_reg;
    logic [31:0]            live_id_reg [ORDER_SLOTS];
    logic [31:0]            pend_id_reg [ORDER_SLOTS];
    logic [ORDER_SLOTS-1:0] live_hit_reg;
    logic [ORDER_SLOTS-1:0] pend_hit_reg;
    logic [IDX_W-1:0]       slot_reg;
    logic                   slot_ok_reg;
    logic                   live_found_reg;
    logic [IDX_W-1:0]       psel_reg;
    logic                   pfound_reg;
    logic                   pok_reg;
    logic [IDX_W-1:0]       fidx_reg;
    logic [55:0]            next_ref_reg;
    logic [63:0]            match_reg;

    // table memories
    logic [55:0]            live_ref_mem [ORDER_SLOTS];
    logic [31:0]            live_qty_mem [ORDER_SLOTS];
    logic [55:0]            pend_ref_mem [ORDER_SLOTS];
    logic [55:0]            live_ref_rd_reg;
    logic [31:0]            live_qty_rd_reg;
    logic [55:0]            pend_ref_rd_reg;

    // output register
    logic                   out_valid_reg;
    logic [2:0]             out_type_reg;
    logic [63:0]            out_time_reg;
    logic [55:0]            out_ref_reg;
    logic [55:0]            out_oref_reg;
    logic                   out_side_reg;
    logic [31:0]            out_qty_reg;
    logic [18:0]            out_tick_reg;
    logic [63:0]            out_match_reg;
    logic                   out_ovf_reg;
    logic                   out_last_reg;

    logic                   out_free;
    logic [IDX_W-1:0]       slot_sel;
    logic [IDX_W-1:0]       psel_sel;
    logic [IDX_W-1:0]       rd_addr;
    logic [ORDER_SLOTS-1:0] above_mask;
    logic [55:0]            ref_new;
    logic                   exec_go;
    logic                   wr_live;
    logic                   wr_qty;
    logic [31:0]            qty_wdata;
    logic                   wr_pend;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign up_ready = (state_reg == ST_IDLE);
    assign exec_go  = (state_reg == ST_EXEC) && out_free;
    assign ref_new  = next_ref_reg + 56'd1;

    // slot choice from the registered search results
    assign slot_sel = (|live_hit_reg) ? lowest(live_hit_reg) : lowest(~live_valid_reg);
    assign psel_sel = (|pend_hit_reg) ? lowest(pend_hit_reg) : lowest(~pend_valid_reg);
    assign rd_addr  = (state_reg == ST_FL_RD) ? fidx_reg : slot_sel;

    // entries above the flush index
    always_comb
    begin
        for (int k = 0; k < ORDER_SLOTS; k++)
        begin
            above_mask[k] = (IDX_W'(k) > fidx_reg) && (k <= ORDER_SLOTS - 1);
        end
    end

    // memory write strobes
    always_comb
    begin
        wr_live   = 1'b0;
        wr_qty    = 1'b0;
        wr_pend   = 1'b0;
        qty_wdata = item_reg.quantity;
        if (exec_go)
        begin
            unique case (item_reg.kind)
                REQ_ACCEPT:
                begin
                    wr_live = slot_ok_reg;
                    wr_qty  = slot_ok_reg;
                end
                REQ_CANCEL:
                begin
                    if (live_found_reg && item_reg.cancel_reason == RSN_REPLACE)
                    begin
                        if (item_reg.quantity < live_qty_rd_reg)
                        begin
                            wr_qty    = 1'b1;
                            qty_wdata = live_qty_rd_reg - item_reg.quantity;
                        end
                        else
                        begin
                            wr_pend = pok_reg;
                        end
                    end
                end
                REQ_TRADE:
                begin
                    wr_qty    = live_found_reg && (item_reg.maker_left != 32'd0);
                    qty_wdata = item_reg.maker_left;
                end
                REQ_RESEED:
                begin
                    wr_qty = 1'b0;
                end
            endcase
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DECIDE || state_reg == ST_FL_RD)
        begin
            live_ref_rd_reg <= live_ref_mem[rd_addr];
            live_qty_rd_reg <= live_qty_mem[rd_addr];
            pend_ref_rd_reg <= pend_ref_mem[psel_sel];
        end
        if (wr_live)
        begin
            live_ref_mem[slot_reg] <= ref_new;
            live_id_reg[slot_reg]  <= item_reg.order_id;
        end
        if (wr_qty)
        begin
            live_qty_mem[slot_reg] <= qty_wdata;
        end
        if (wr_pend)
        begin
            pend_ref_mem[psel_reg] <= live_ref_rd_reg;
            pend_id_reg[psel_reg]  <= item_reg.order_id;
        end
    end

    // payload registers without reset
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            item_reg <= up_item;
        end
        if (state_reg == ST_SEARCH)
        begin
            for (int k = 0; k < ORDER_SLOTS; k++)
            begin
                live_hit_reg[k] <= live_valid_reg[k] && (live_id_reg[k] == item_reg.order_id);
                pend_hit_reg[k] <= pend_valid_reg[k] && (pend_id_reg[k] == item_reg.order_id);
            end
        end
        if (state_reg == ST_DECIDE)
        begin
            slot_reg       <= slot_sel;
            slot_ok_reg    <= (|live_hit_reg) || !(&live_valid_reg);
            live_found_reg <= |live_hit_reg;
            psel_reg       <= psel_sel;
            pfound_reg     <= |pend_hit_reg;
            pok_reg        <= (|pend_hit_reg) || !(&pend_valid_reg);
        end
    end

    // sequencer, tables and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            live_valid_reg <= '0;
            pend_valid_reg <= '0;
            fidx_reg       <= '0;
            next_ref_reg   <= '0;
            match_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_type_reg   <= MSG_ADD;
            out_time_reg   <= '0;
            out_ref_reg    <= '0;
            out_oref_reg   <= '0;
            out_side_reg   <= 1'b0;
            out_qty_reg    <= '0;
            out_tick_reg   <= '0;
            out_match_reg  <= '0;
            out_ovf_reg    <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (up_valid)
                    begin
                        if (up_item.kind == REQ_RESEED)
                        begin
                            fidx_reg <= '0;
                            if (live_valid_reg == '0)
                            begin
                                pend_valid_reg <= '0;
                            end
                            else
                            begin
                                state_reg <= ST_FL_RD;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_SEARCH;
                        end
                    end
                end
                ST_SEARCH:
                begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    if (out_free)
                    begin
                        state_reg     <= ST_IDLE;
                        out_time_reg  <= item_reg.event_time;
                        out_ref_reg   <= live_ref_rd_reg;
                        out_oref_reg  <= '0;
                        out_side_reg  <= 1'b0;
                        out_qty_reg   <= item_reg.quantity;
                        out_tick_reg  <= '0;
                        out_match_reg <= '0;
                        out_ovf_reg   <= 1'b0;
                        out_last_reg  <= 1'b1;
                        unique case (item_reg.kind)
                            REQ_ACCEPT:
                            begin
                                next_ref_reg  <= ref_new;
                                out_valid_reg <= 1'b1;
                                out_ref_reg   <= ref_new;
                                out_tick_reg  <= item_reg.price_tick;
                                out_ovf_reg   <= !slot_ok_reg;
                                if (pfound_reg)
                                begin
                                    out_type_reg             <= MSG_REPLACE;
                                    out_oref_reg             <= pend_ref_rd_reg;
                                    pend_valid_reg[psel_reg] <= 1'b0;
                                end
                                else
                                begin
                                    out_type_reg <= MSG_ADD;
                                    out_side_reg <= item_reg.side;
                                end
                                if (slot_ok_reg)
                                begin
                                    live_valid_reg[slot_reg] <= 1'b1;
                                end
                            end
                            REQ_CANCEL:
                            begin
                                if (live_found_reg)
                                begin
                                    if (item_reg.cancel_reason == RSN_REPLACE)
                                    begin
                                        if (item_reg.quantity < live_qty_rd_reg)
                                        begin
                                            out_valid_reg <= 1'b1;
                                            out_type_reg  <= MSG_CANCEL;
                                        end
                                        else
                                        begin
                                            live_valid_reg[slot_reg] <= 1'b0;
                                            if (pok_reg)
                                            begin
                                                pend_valid_reg[psel_reg] <= 1'b1;
                                            end
                                        end
                                    end
                                    else if (item_reg.cancel_reason == RSN_WITHDRAW)
                                    begin
                                        out_valid_reg            <= 1'b1;
                                        out_type_reg             <= MSG_DELETE;
                                        out_qty_reg              <= '0;
                                        live_valid_reg[slot_reg] <= 1'b0;
                                    end
                                end
                            end
                            REQ_TRADE:
                            begin
                                if (live_found_reg)
                                begin
                                    match_reg     <= match_reg + 64'd1;
                                    out_valid_reg <= 1'b1;
                                    out_type_reg  <= MSG_EXECUTED;
                                    out_match_reg <= match_reg + 64'd1;
                                    if (item_reg.maker_left == 32'd0)
                                    begin
                                        live_valid_reg[slot_reg] <= 1'b0;
                                    end
                                end
                            end
                            REQ_RESEED:
                            begin
                                out_last_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_FL_RD:
                begin
                    state_reg <= ST_FL_EMIT;
                end
                ST_FL_EMIT:
                begin
                    if (!live_valid_reg[fidx_reg] || out_free)
                    begin
                        if (live_valid_reg[fidx_reg])
                        begin
                            out_valid_reg <= 1'b1;
                            out_type_reg  <= MSG_DELETE;
                            out_time_reg  <= item_reg.event_time;
                            out_ref_reg   <= live_ref_rd_reg;
                            out_oref_reg  <= '0;
                            out_side_reg  <= 1'b0;
                            out_qty_reg   <= '0;
                            out_tick_reg  <= '0;
                            out_match_reg <= '0;
                            out_ovf_reg   <= 1'b0;
                            out_last_reg  <= !(|(live_valid_reg & above_mask));
                        end
                        if (fidx_reg == LAST_IDX)
                        begin
                            live_valid_reg <= '0;
                            pend_valid_reg <= '0;
                            state_reg      <= ST_IDLE;
                        end
                        else
                        begin
                            fidx_reg  <= fidx_reg + IDX_W'(1);
                            state_reg <= ST_FL_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_ovf_reg, out_type_reg};
    assign m_axis_tdata  = {4'd0, out_match_reg, out_tick_reg, out_qty_reg, out_side_reg,
                            out_oref_reg, out_ref_reg, out_time_reg};

endmodule

FILE: verif/order_event_to_itch_translator_core_test.sv
// Testbench for the order event to ITCH translator: directed table plus random events.
module order_event_to_itch_translator_core_test;
    import oeit_pkg::*;

    localparam int SLOTS = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [2:0]  mtype;
        logic [63:0] mtime;
        logic [55:0] ref_no;
        logic [55:0] old_ref;
        logic        mside;
        logic [31:0] qty;
        logic [18:0] tick;
        logic [63:0] match_no;
        logic        ovf;
        logic        tlast;
    } itch_msg_t;

    // One directed stimulus row; has_fixed marks a typed-in expected message
    typedef struct {
        req_kind_t   kind;
        logic [63:0] etime;
        logic [31:0] oid;
        logic        side;
        logic [31:0] qty;
        logic [18:0] tick;
        logic [1:0]  reason;
        logic [31:0] remain;
        bit          has_fixed;
        itch_msg_t   fixed;
    } event_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [3:0] m_axis_tuser;
    logic m_axis_tlast;

    // Predictor copy of the order tables
    bit          book_valid [SLOTS];
    logic [31:0] book_id    [SLOTS];
    logic [55:0] book_ref   [SLOTS];
    logic [31:0] book_qty   [SLOTS];
    logic [18:0] book_tick  [SLOTS];
    logic        book_side  [SLOTS];
    bit          park_valid [SLOTS];
    logic [31:0] park_id    [SLOTS];
    logic [55:0] park_ref   [SLOTS];
    logic [55:0] ref_counter;
    logic [63:0] match_count;

    itch_msg_t expected_msgs[$];
    event_row_t dir_rows[$];
    int  error_count = 0;
    int  idle_cycles = 0;

    order_event_to_itch_translator_core #(.ORDER_SLOTS(SLOTS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic add_row(input event_row_t ev);
        dir_rows.insert(dir_rows.size(), ev);
    endtask

    function automatic int find_book(input logic [31:0] oid);
        for (int i = 0; i < SLOTS; i++)
            if (book_valid[i] && book_id[i] == oid) return i;
        return -1;
    endfunction

    function automatic int find_park(input logic [31:0] oid);
        for (int i = 0; i < SLOTS; i++)
            if (park_valid[i] && park_id[i] == oid) return i;
        return -1;
    endfunction

    function automatic int first_free(input bit v[SLOTS]);
        for (int i = 0; i < SLOTS; i++)
            if (!v[i]) return i;
        return -1;
    endfunction

    function automatic itch_msg_t make_msg(input logic [2:0] mt, input logic [63:0] tm,
            input logic [55:0] r, input logic [55:0] o, input logic sd,
            input logic [31:0] q, input logic [18:0] tk, input logic [63:0] mn,
            input logic ov);
        itch_msg_t m;
        m.mtype = mt; m.mtime = tm; m.ref_no = r; m.old_ref = o; m.mside = sd;
        m.qty = q; m.tick = tk; m.match_no = mn; m.ovf = ov; m.tlast = 1'b0;
        return m;
    endfunction

    // Translate one event into ITCH messages and update the order tables
    task automatic translate_event(input event_row_t ev);
        itch_msg_t out[$];
        int s;
        int p;
        logic [55:0] r;
        bit ov;
        case (ev.kind)
            REQ_RESEED:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (book_valid[i])
                        out.insert(out.size(), make_msg(MSG_DELETE, ev.etime, book_ref[i],
                                                        0, 0, 0, 0, 0, 0));
                    book_valid[i] = 0;
                    park_valid[i] = 0;
                end
            end
            REQ_ACCEPT:
            begin
                ref_counter = ref_counter + 1;
                r = ref_counter;
                s = find_book(ev.oid);
                if (s < 0) s = first_free(book_valid);
                ov = (s < 0);
                p = find_park(ev.oid);
                if (p >= 0)
                begin
                    park_valid[p] = 0;
                    out.insert(out.size(), make_msg(MSG_REPLACE, ev.etime, r, park_ref[p], 0,
                                                    ev.qty, ev.tick, 0, ov));
                end
                else
                    out.insert(out.size(), make_msg(MSG_ADD, ev.etime, r, 0, ev.side, ev.qty,
                                                    ev.tick, 0, ov));
                if (!ov)
                begin
                    book_valid[s] = 1; book_id[s] = ev.oid; book_ref[s] = r;
                    book_qty[s] = ev.qty; book_tick[s] = ev.tick; book_side[s] = ev.side;
                end
            end
            REQ_CANCEL:
            begin
                s = find_book(ev.oid);
                if (ev.reason == RSN_IOC || ev.reason == RSN_FOK || s < 0)
                    ;
                else if (ev.reason == RSN_REPLACE && ev.qty < book_qty[s])
                begin
                    out.insert(out.size(), make_msg(MSG_CANCEL, ev.etime, book_ref[s], 0, 0,
                                                    ev.qty, 0, 0, 0));
                    book_qty[s] = book_qty[s] - ev.qty;
                end
                else if (ev.reason == RSN_REPLACE)
                begin
                    p = find_park(ev.oid);
                    if (p < 0) p = first_free(park_valid);
                    if (p >= 0)
                    begin
                        park_valid[p] = 1; park_id[p] = ev.oid; park_ref[p] = book_ref[s];
                    end
                    book_valid[s] = 0;
                end
                else
                begin
                    out.insert(out.size(), make_msg(MSG_DELETE, ev.etime, book_ref[s], 0, 0,
                                                    0, 0, 0, 0));
                    book_valid[s] = 0;
                end
            end
            default:
            begin
                s = find_book(ev.oid);
                if (s >= 0)
                begin
                    match_count = match_count + 1;
                    out.insert(out.size(), make_msg(MSG_EXECUTED, ev.etime, book_ref[s], 0, 0,
                                                    ev.qty, 0, match_count, 0));
                    if (ev.remain == 0) book_valid[s] = 0;
                    else book_qty[s] = ev.remain;
                end
            end
        endcase
        if (out.size() > 0) out[out.size() - 1].tlast = 1'b1;
        // A typed-in row must agree with the predictor as well
        if (ev.has_fixed)
        begin
            if (out.size() != 1 || out[0] != ev.fixed)
                report_mismatch("directed row", out.size(), 1);
        end
        foreach (out[i]) expected_msgs.insert(expected_msgs.size(), out[i]);
    endtask

    // Send one event transaction; gap first, then hold until accepted
    task automatic send_event(input event_row_t ev);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ev.kind;
        s_axis_tdata  <= {2'b0, ev.remain, ev.reason, ev.tick, ev.qty, ev.side, ev.oid,
                          ev.etime};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        translate_event(ev);
    endtask

    function automatic event_row_t mk(input req_kind_t k, input logic [63:0] t,
            input logic [31:0] id, input logic sd, input logic [31:0] q,
            input logic [18:0] tk, input logic [1:0] rs, input logic [31:0] rm);
        event_row_t e;
        e.kind = k; e.etime = t; e.oid = id; e.side = sd; e.qty = q; e.tick = tk;
        e.reason = rs; e.remain = rm; e.has_fixed = 0;
        e.fixed = make_msg(0, 0, 0, 0, 0, 0, 0, 0, 0);
        return e;
    endfunction

    // Result side: random stall, compare each message with the oldest expectation
    always @(posedge clk)
    begin
        itch_msg_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            idle_cycles <= 0;
            if (expected_msgs.size() == 0)
                report_mismatch("unexpected message", m_axis_tuser, 0);
            else
            begin
                want = expected_msgs.pop_front();
                if (m_axis_tuser[2:0] != want.mtype)
                    report_mismatch("msg_type", m_axis_tuser[2:0], want.mtype);
                if (m_axis_tuser[3] != want.ovf)
                    report_mismatch("overflow", m_axis_tuser[3], want.ovf);
                if (m_axis_tlast != want.tlast)
                    report_mismatch("last", m_axis_tlast, want.tlast);
                if (m_axis_tdata[63:0] != want.mtime)
                    report_mismatch("msg_time", m_axis_tdata[63:0], want.mtime);
                if (m_axis_tdata[119:64] != want.ref_no)
                    report_mismatch("order_ref", m_axis_tdata[119:64], want.ref_no);
                if (m_axis_tdata[175:120] != want.old_ref)
                    report_mismatch("old_ref", m_axis_tdata[175:120], want.old_ref);
                if (m_axis_tdata[176] != want.mside)
                    report_mismatch("msg_side", m_axis_tdata[176], want.mside);
                if (m_axis_tdata[208:177] != want.qty)
                    report_mismatch("msg_qty", m_axis_tdata[208:177], want.qty);
                if (m_axis_tdata[227:209] != want.tick)
                    report_mismatch("msg_tick", m_axis_tdata[227:209], want.tick);
                if (m_axis_tdata[291:228] != want.match_no)
                    report_mismatch("match_number", m_axis_tdata[291:228], want.match_no);
            end
        end
        else if (rst_n && s_axis_tvalid && s_axis_tready)
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
    end

    // Result-side backpressure: runs of ready, short stalls, an occasional long one
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            n = $urandom_range(0, 15);
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clk);
            m_axis_tready <= 1'b0;
            repeat ((n == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3)) @(negedge clk);
        end
    end

    // Watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        event_row_t e;
        logic [31:0] pool [8];
        int k;
        int r;
        ref_counter = 0;
        match_count = 0;
        foreach (book_valid[i])
        begin
            book_valid[i] = 0;
            park_valid[i] = 0;
        end
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_RESEED;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed table: empty reseed, extreme accept, every cancel reason, trades
        add_row(mk(REQ_RESEED, 64'd5, 0, 0, 0, 0, 0, 0));
        e = mk(REQ_ACCEPT, '1, '1, 1, '1, 19'h7ffff, 0, 0);
        e.has_fixed = 1;
        e.fixed = make_msg(MSG_ADD, '1, 56'd1, 0, 1, '1, 19'h7ffff, 0, 0);
        e.fixed.tlast = 1;
        add_row(e);
        e = mk(REQ_ACCEPT, 0, 0, 0, 0, 0, 0, 0);
        e.has_fixed = 1;
        e.fixed = make_msg(MSG_ADD, 0, 56'd2, 0, 0, 0, 0, 0, 0);
        e.fixed.tlast = 1;
        add_row(e);
        add_row(mk(REQ_TRADE, 10, '1, 0, 100, 0, 0, 50));
        add_row(mk(REQ_TRADE, 11, 32'h77, 0, 1, 0, 0, 0));
        add_row(mk(REQ_CANCEL, 12, '1, 0, 1, 0, RSN_IOC, 0));
        add_row(mk(REQ_CANCEL, 13, '1, 0, 1, 0, RSN_FOK, 0));
        add_row(mk(REQ_CANCEL, 14, '1, 0, 10, 0, RSN_REPLACE, 0));
        add_row(mk(REQ_CANCEL, 15, '1, 0, 40, 0, RSN_REPLACE, 0));
        add_row(mk(REQ_ACCEPT, 16, '1, 1, 77, 12345, 0, 0));
        add_row(mk(REQ_CANCEL, 17, 0, 0, 0, 0, RSN_WITHDRAW, 0));
        add_row(mk(REQ_CANCEL, 18, 32'h55, 0, 0, 0, RSN_WITHDRAW, 0));
        add_row(mk(REQ_ACCEPT, 19, 32'h10, 0, 5, 1, 0, 0));
        add_row(mk(REQ_ACCEPT, 20, 32'h10, 1, 6, 2, 0, 0));
        add_row(mk(REQ_TRADE, 21, 32'h10, 0, '1, 0, 0, '1));
        add_row(mk(REQ_TRADE, 22, 32'h10, 0, 6, 0, 0, 0));
        add_row(mk(REQ_RESEED, 23, 0, 0, 0, 0, 0, 0));
        foreach (dir_rows[i]) send_event(dir_rows[i]);

        // Fill the live table past capacity, park replaces, then flush
        for (int i = 0; i < SLOTS + 3; i++)
            send_event(mk(REQ_ACCEPT, i, 32'h1000 + i, i[0], i + 1, i, 0, 0));
        for (int i = 0; i < 4; i++)
            send_event(mk(REQ_CANCEL, 99, 32'h1000 + i, 0, '1, 0, RSN_REPLACE, 0));
        send_event(mk(REQ_ACCEPT, 100, 32'h1000 + 1, 0, 9, 9, 0, 0));
        send_event(mk(REQ_ACCEPT, 101, 32'h9999, 1, 9, 9, 0, 0));
        send_event(mk(REQ_RESEED, '1, 0, 0, 0, 0, 0, 0));

        // Random part: mostly lifecycles over a small id pool, some noise
        for (int n = 0; n < 310; n++)
        begin
            if (n % 8 == 0)
                foreach (pool[i]) pool[i] = $urandom;
            k = $urandom_range(0, 99);
            r = $urandom_range(0, 7);
            e = mk(REQ_ACCEPT, {$urandom, $urandom}, pool[r], $urandom_range(0, 1),
                   $urandom_range(1, 1000), $urandom, $urandom_range(0, 3), 0);
            if ($urandom_range(0, 9) == 0) e.oid = $urandom;
            if ($urandom_range(0, 9) == 0) e.qty = $urandom;
            if (k < 35)
                e.kind = REQ_ACCEPT;
            else if (k < 65)
            begin
                e.kind = REQ_CANCEL;
                if ($urandom_range(0, 1)) e.reason = RSN_REPLACE;
            end
            else if (k < 97)
            begin
                e.kind = REQ_TRADE;
                e.remain = $urandom_range(0, 2) == 0 ? 0 : $urandom;
            end
            else
                e.kind = REQ_RESEED;
            send_event(e);
        end

        // release the input after the last transaction
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        while (expected_msgs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_msgs.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/oeit_pkg.sv
hw/rtl/oeit_front.sv
hw/rtl/oeit_queue.sv
hw/rtl/oeit_back.sv
hw/rtl/order_event_to_itch_translator_core.sv
verif/order_event_to_itch_translator_core_test.sv
